>>> design/grhd_pkg.sv
// Shared types and constants for the graph reachability / hop distance block.
// No dependencies; used by grhd_adj_matrix and graph_reachability_hop_distance.
package grhd_pkg;

    localparam int NODE_COUNT = 16;
    localparam int NODE_W     = 4;
    localparam int CNT_W      = 9;
    localparam int HOP_W      = 5;
    localparam int LEVEL_W    = 4;

    typedef logic [NODE_COUNT-1:0] node_mask_t;
    typedef logic [NODE_W-1:0]     node_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [LEVEL_W-1:0]    level_t;
    typedef logic signed [HOP_W-1:0] hop_t;

    localparam cnt_t   CNT_MAX     = '1;
    localparam level_t LEVEL_MAX   = '1;
    localparam hop_t   HOP_UNREACH = -5'sd1;
    localparam hop_t   HOP_DIRECT  = 5'sd1;
    localparam hop_t   HOP_NONE    = 5'sd0;

    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_SEARCH,
        ST_WRITE
    } state_t;

    // write command toward the adjacency matrix
    typedef struct packed {
        logic  en;
        node_t node_a;
        node_t node_b;
    } adj_wr_t;

endpackage

>>> design/grhd_adj_matrix.sv
// Undirected adjacency bit matrix with symmetric edge write, one row read port
// and the frontier expansion unit. Depends on grhd_pkg.
module grhd_adj_matrix (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  grhd_pkg::adj_wr_t     wr,
    input  grhd_pkg::node_t       rd_node,
    output grhd_pkg::node_mask_t  rd_row,
    input  grhd_pkg::node_mask_t  frontier,
    input  grhd_pkg::node_mask_t  visited,
    output grhd_pkg::node_mask_t  next_mask
);

    grhd_pkg::node_mask_t rows_reg [grhd_pkg::NODE_COUNT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < grhd_pkg::NODE_COUNT; i++) begin
                rows_reg[i] <= '0;
            end
        end else if (wr.en) begin
            // a self-loop sets the same bit from both terms
            for (int i = 0; i < grhd_pkg::NODE_COUNT; i++) begin
                rows_reg[i] <= rows_reg[i]
                    | ((grhd_pkg::node_t'(i) == wr.node_a) ?
                       grhd_pkg::node_mask_t'(1) << wr.node_b : '0)
                    | ((grhd_pkg::node_t'(i) == wr.node_b) ?
                       grhd_pkg::node_mask_t'(1) << wr.node_a : '0);
            end
        end
    end

    assign rd_row = rows_reg[rd_node];

    // one BFS level: OR of the rows of all frontier nodes, minus visited
    always_comb begin
        grhd_pkg::node_mask_t acc;
        acc = '0;
        for (int i = 0; i < grhd_pkg::NODE_COUNT; i++) begin
            if (frontier[i]) begin
                acc = acc | rows_reg[i];
            end
        end
        next_mask = acc & ~visited;
    end

endmodule

>>> design/graph_reachability_hop_distance.sv
// An edge add passes through ST_ADD and ST_WRITE to m_valid; a query passes through
// ST_SEARCH (one BFS level per cycle in the matrix expansion unit, 1 to 16 levels)
// and ST_WRITE. One item at a time: s_ready returns as the result loads, and a result
// waiting in the output register holds back only the next item's final write.
// Synchronous active-low reset clears the matrix, the entry counter and all control
// state. Depends on grhd_pkg, grhd_adj_matrix.
module graph_reachability_hop_distance (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_mode,
    input  logic [3:0]            s_node_a,
    input  logic [3:0]            s_node_b,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_direct_edge,
    output logic                  m_reachable,
    output logic signed [4:0]     m_hop_distance,
    output logic [8:0]            m_edge_entries
);

    grhd_pkg::state_t     state_reg, state_next;
    grhd_pkg::node_t      node_a_reg, node_b_reg;
    grhd_pkg::node_mask_t frontier_reg, visited_reg;
    grhd_pkg::level_t     level_reg;
    grhd_pkg::cnt_t       cnt_reg;
    grhd_pkg::hop_t       hop_reg;
    logic                 direct_reg, reach_reg;
    logic                 m_valid_reg;
    logic                 m_direct_reg, m_reach_reg;
    grhd_pkg::hop_t       m_hop_reg;
    grhd_pkg::cnt_t       m_cnt_reg;

    grhd_pkg::adj_wr_t    wr;
    grhd_pkg::node_mask_t rd_row, next_mask;

    logic                 accept, out_free, hit, empty;
    logic [1:0]           added;
    logic [grhd_pkg::CNT_W:0] cnt_sum;

    grhd_adj_matrix u_matrix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr        (wr),
        .rd_node   (node_a_reg),
        .rd_row    (rd_row),
        .frontier  (frontier_reg),
        .visited   (visited_reg),
        .next_mask (next_mask)
    );

    assign s_ready  = (state_reg == grhd_pkg::ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign hit      = frontier_reg[node_b_reg];
    assign empty    = (frontier_reg == '0);

    assign wr.en     = (state_reg == grhd_pkg::ST_ADD);
    assign wr.node_a = node_a_reg;
    assign wr.node_b = node_b_reg;

    // entries newly set by an add: two for a fresh edge, one for a fresh self-loop
    assign added   = rd_row[node_b_reg] ? 2'd0 :
                     (node_a_reg == node_b_reg) ? 2'd1 : 2'd2;
    assign cnt_sum = {1'b0, cnt_reg} + (grhd_pkg::CNT_W + 1)'(added);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= grhd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            grhd_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = (s_mode == grhd_pkg::MODE_QUERY) ?
                                 grhd_pkg::ST_SEARCH : grhd_pkg::ST_ADD;
                end
            end
            grhd_pkg::ST_ADD: begin
                state_next = grhd_pkg::ST_WRITE;
            end
            grhd_pkg::ST_SEARCH: begin
                if (hit || empty) begin
                    state_next = grhd_pkg::ST_WRITE;
                end
            end
            grhd_pkg::ST_WRITE: begin
                if (out_free) begin
                    state_next = grhd_pkg::ST_IDLE;
                end
            end
            default: state_next = grhd_pkg::ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (state_reg == grhd_pkg::ST_ADD) begin
                cnt_reg <= cnt_sum[grhd_pkg::CNT_W] ? grhd_pkg::CNT_MAX
                                                    : cnt_sum[grhd_pkg::CNT_W-1:0];
            end
            if (state_reg == grhd_pkg::ST_WRITE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            node_a_reg   <= s_node_a;
            node_b_reg   <= s_node_b;
            frontier_reg <= grhd_pkg::node_mask_t'(1) << s_node_a;
            visited_reg  <= grhd_pkg::node_mask_t'(1) << s_node_a;
            level_reg    <= '0;
        end
        if (state_reg == grhd_pkg::ST_ADD) begin
            direct_reg <= 1'b0;
            reach_reg  <= 1'b0;
            hop_reg    <= grhd_pkg::HOP_NONE;
        end
        if (state_reg == grhd_pkg::ST_SEARCH) begin
            direct_reg <= rd_row[node_b_reg];
            if (hit) begin
                reach_reg <= 1'b1;
                hop_reg   <= grhd_pkg::hop_t'({1'b0, level_reg});
            end else if (empty) begin
                reach_reg <= 1'b0;
                hop_reg   <= grhd_pkg::HOP_UNREACH;
            end else begin
                frontier_reg <= next_mask;
                visited_reg  <= visited_reg | next_mask;
                level_reg    <= (level_reg == grhd_pkg::LEVEL_MAX) ? level_reg
                                : level_reg + grhd_pkg::level_t'(1);
            end
        end
        if (state_reg == grhd_pkg::ST_WRITE && out_free) begin
            m_direct_reg <= direct_reg;
            m_reach_reg  <= reach_reg;
            // a direct edge (self-loop included) always reports one hop
            m_hop_reg    <= direct_reg ? grhd_pkg::HOP_DIRECT : hop_reg;
            m_cnt_reg    <= cnt_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_direct_edge  = m_direct_reg;
    assign m_reachable    = m_reach_reg;
    assign m_hop_distance = m_hop_reg;
    assign m_edge_entries = m_cnt_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> cnt_reg >= $past(cnt_reg))
        else $error("entry counter decreased");

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == grhd_pkg::ST_SEARCH |-> (frontier_reg & ~visited_reg) == '0)
        else $error("frontier holds an unvisited node");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_direct_edge |-> m_reachable && m_hop_distance == grhd_pkg::HOP_DIRECT)
        else $error("direct edge without one-hop reachability");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_reachable == (m_hop_distance >= 0)) ||
                    (!m_reachable && m_hop_distance == grhd_pkg::HOP_NONE))
        else $error("reachable flag disagrees with hop distance");

endmodule

>>> tb/graph_reachability_hop_distance_test.sv
// Self-checking testbench for graph_reachability_hop_distance: edge adds and BFS hop queries,
// predicted by a local graph copy and checked per field with random stalls on both channels.
// Depends on grhd_pkg and the graph_reachability_hop_distance RTL.
module graph_reachability_hop_distance_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 60;
    localparam int RANDOM_ITEMS = 1750;

    typedef struct packed {
        logic           direct_edge;
        logic           reachable;
        grhd_pkg::hop_t hop_distance;
        grhd_pkg::cnt_t edge_entries;
    } hop_report_t;

    logic            aclk = 1'b0;
    logic            aresetn = 1'b0;
    logic            s_valid = 1'b0;
    logic            s_ready;
    logic            s_mode = grhd_pkg::MODE_ADD;
    grhd_pkg::node_t s_node_a = '0;
    grhd_pkg::node_t s_node_b = '0;
    logic            m_valid;
    logic            m_ready = 1'b0;
    logic            m_direct_edge;
    logic            m_reachable;
    grhd_pkg::hop_t  m_hop_distance;
    grhd_pkg::cnt_t  m_edge_entries;

    // local copy of the graph
    grhd_pkg::node_mask_t adj_rows [grhd_pkg::NODE_COUNT];
    grhd_pkg::cnt_t       set_entries;
    hop_report_t          reports_due [$];

    int          fail_count = 0;
    int unsigned cycle_count = 0;
    bit          quiet = 1'b0;

    graph_reachability_hop_distance i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_node_a       (s_node_a),
        .s_node_b       (s_node_b),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_direct_edge  (m_direct_edge),
        .m_reachable    (m_reachable),
        .m_hop_distance (m_hop_distance),
        .m_edge_entries (m_edge_entries)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // mostly short gaps, a few long ones; none while quiet
    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    // level-synchronous search; level of dst or HOP_UNREACH
    function automatic grhd_pkg::hop_t bfs_level(grhd_pkg::node_t src, grhd_pkg::node_t dst);
        grhd_pkg::node_mask_t visited;
        grhd_pkg::node_mask_t frontier;
        grhd_pkg::node_mask_t reach_next;
        int level;
        visited  = grhd_pkg::node_mask_t'(1) << src;
        frontier = visited;
        for (level = 0; level <= grhd_pkg::NODE_COUNT; level++) begin
            if (frontier[dst])
                return (level > 15) ? grhd_pkg::hop_t'(15) : grhd_pkg::hop_t'(level);
            if (frontier == '0)
                return grhd_pkg::HOP_UNREACH;
            reach_next = '0;
            for (int i = 0; i < grhd_pkg::NODE_COUNT; i++)
                if (frontier[i])
                    reach_next |= adj_rows[i];
            reach_next &= ~visited;
            visited    |= reach_next;
            frontier    = reach_next;
        end
        return grhd_pkg::HOP_UNREACH;
    endfunction

    // applies one item to the local graph and returns the report it should produce
    // (node fields are 4 bits wide, so every index is inside the matrix)
    function automatic hop_report_t graph_step(logic mode, grhd_pkg::node_t a,
                                               grhd_pkg::node_t b);
        hop_report_t rpt;
        int added;
        rpt   = '0;
        added = 0;
        if (mode == grhd_pkg::MODE_ADD) begin
            if (!adj_rows[a][b]) begin
                adj_rows[a][b] = 1'b1;
                added++;
            end
            if (!adj_rows[b][a]) begin
                adj_rows[b][a] = 1'b1;
                added++;
            end
            if (int'(set_entries) + added > int'(grhd_pkg::CNT_MAX))
                set_entries = grhd_pkg::CNT_MAX;
            else
                set_entries = set_entries + grhd_pkg::cnt_t'(added);
        end else begin
            rpt.direct_edge  = adj_rows[a][b];
            rpt.hop_distance = bfs_level(a, b);
            rpt.reachable    = (rpt.hop_distance != grhd_pkg::HOP_UNREACH);
            if (adj_rows[a][b] || adj_rows[b][a])
                rpt.hop_distance = grhd_pkg::HOP_DIRECT;
        end
        rpt.edge_entries = set_entries;
        return rpt;
    endfunction

    task automatic send_item(logic mode, grhd_pkg::node_t a, grhd_pkg::node_t b);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid  <= 1'b1;
        s_mode   <= mode;
        s_node_a <= a;
        s_node_b <= b;
        do @(posedge aclk); while (s_ready !== 1'b1);
        reports_due.push_back(graph_step(mode, a, b));
    endtask

    // result side: random stalls
    initial begin
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = pick_gap();
            if (stall != 0) begin
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
            @(negedge aclk);
            m_ready <= 1'b1;
            repeat ($urandom_range(0, 15)) @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        hop_report_t want;
        if (aresetn && m_valid && m_ready) begin
            if (reports_due.size() == 0) begin
                $error("result transfer with no item outstanding");
                fail_count++;
            end else begin
                want = reports_due.pop_front();
                if (m_direct_edge !== want.direct_edge) begin
                    $error("direct_edge: expected %0d, actual %0d",
                           want.direct_edge, m_direct_edge);
                    fail_count++;
                end
                if (m_reachable !== want.reachable) begin
                    $error("reachable: expected %0d, actual %0d",
                           want.reachable, m_reachable);
                    fail_count++;
                end
                if (m_hop_distance !== want.hop_distance) begin
                    $error("hop_distance: expected %0d, actual %0d",
                           want.hop_distance, m_hop_distance);
                    fail_count++;
                end
                if (m_edge_entries !== want.edge_entries) begin
                    $error("edge_entries: expected %0d, actual %0d",
                           want.edge_entries, m_edge_entries);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("** graph_reachability_hop_distance: FAILED **");
        $finish;
    end

    // no edges yet: a node reaches itself at level 0, nothing else
    task automatic test_empty_graph();
        send_item(grhd_pkg::MODE_QUERY, 4'd0, 4'd0);
        send_item(grhd_pkg::MODE_QUERY, 4'd0, 4'd15);
        send_item(grhd_pkg::MODE_QUERY, 4'd15, 4'd15);
        send_item(grhd_pkg::MODE_QUERY, 4'd15, 4'd0);
    endtask

    // self-loop counts one entry, re-adding it changes nothing
    task automatic test_self_loop();
        send_item(grhd_pkg::MODE_ADD, 4'd15, 4'd15);
        send_item(grhd_pkg::MODE_ADD, 4'd15, 4'd15);
        send_item(grhd_pkg::MODE_QUERY, 4'd15, 4'd15);
    endtask

    // path 0-1-...-15 gives the longest possible hop count
    task automatic test_long_chain();
        for (int i = 0; i < grhd_pkg::NODE_COUNT - 1; i++) begin
            if (i[0])
                send_item(grhd_pkg::MODE_ADD, grhd_pkg::node_t'(i + 1), grhd_pkg::node_t'(i));
            else
                send_item(grhd_pkg::MODE_ADD, grhd_pkg::node_t'(i), grhd_pkg::node_t'(i + 1));
            if (i == 7)
                send_item(grhd_pkg::MODE_QUERY, 4'd0, 4'd15);
        end
        send_item(grhd_pkg::MODE_QUERY, 4'd0, 4'd15);
        send_item(grhd_pkg::MODE_QUERY, 4'd15, 4'd0);
        send_item(grhd_pkg::MODE_QUERY, 4'd0, 4'd1);
    endtask

    // sparse adds first so long paths survive a while, denser later
    task automatic test_random_traffic(int n);
        for (int i = 0; i < n; i++) begin
            logic            is_add;
            grhd_pkg::node_t a;
            grhd_pkg::node_t b;
            quiet  = (i >= n / 4) && (i < n / 4 + 120);
            is_add = ($urandom_range(0, 99) < ((i < n / 2) ? 2 : 15));
            a      = grhd_pkg::node_t'($urandom_range(0, grhd_pkg::NODE_COUNT - 1));
            b      = ($urandom_range(0, 7) == 0) ? a
                     : grhd_pkg::node_t'($urandom_range(0, grhd_pkg::NODE_COUNT - 1));
            send_item(is_add ? grhd_pkg::MODE_ADD : grhd_pkg::MODE_QUERY, a, b);
        end
        quiet = 1'b0;
    endtask

    // complete graph with every self-loop: all 256 entries set
    task automatic test_fill_matrix();
        quiet = 1'b1;
        for (int a = 0; a < grhd_pkg::NODE_COUNT; a++)
            for (int b = a; b < grhd_pkg::NODE_COUNT; b++)
                send_item(grhd_pkg::MODE_ADD, grhd_pkg::node_t'(b), grhd_pkg::node_t'(a));
        quiet = 1'b0;
        repeat (8)
            send_item(grhd_pkg::MODE_QUERY,
                      grhd_pkg::node_t'($urandom_range(0, grhd_pkg::NODE_COUNT - 1)),
                      grhd_pkg::node_t'($urandom_range(0, grhd_pkg::NODE_COUNT - 1)));
    endtask

    initial begin
        foreach (adj_rows[i])
            adj_rows[i] = '0;
        set_entries = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_graph();
        test_self_loop();
        test_long_chain();
        test_random_traffic(RANDOM_ITEMS);
        test_fill_matrix();

        @(negedge aclk);
        s_valid <= 1'b0;
        while (reports_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("** graph_reachability_hop_distance: PASSED **");
        else
            $display("** graph_reachability_hop_distance: FAILED **");
        $finish;
    end

endmodule

>>> filelist.f
design/grhd_pkg.sv
design/grhd_adj_matrix.sv
design/graph_reachability_hop_distance.sv
tb/graph_reachability_hop_distance_test.sv
